[design/pixel_frame_sample_packer_unit_defines.svh]
// ----------------------------------------------------------------------------
// pixel frame sample packer assertion macros
// shared helpers for the concurrent checks in the packer modules
// ----------------------------------------------------------------------------
`ifndef PIXEL_FRAME_SAMPLE_PACKER_UNIT_DEFINES_SVH
`define PIXEL_FRAME_SAMPLE_PACKER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PFSP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define PFSP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/pfsp_pkg.sv]
// ----------------------------------------------------------------------------
// pfsp_pkg
// types and constants shared by the pixel frame sample packer modules
// ----------------------------------------------------------------------------
package pfsp_pkg;

   localparam logic [7:0] START_MARKER = 8'hAC;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_FRAME_COLUMNS    = 2'd0;
   localparam logic [1:0] CSR_FRAME_ROWS       = 2'd1;
   localparam logic [1:0] CSR_PACKET_BYTES     = 2'd2;
   localparam logic [1:0] CSR_FRAME_DESCRIPTOR = 2'd3;

   localparam logic [7:0] RESET_FRAME_COLUMNS    = 8'd20;
   localparam logic [7:0] RESET_FRAME_ROWS       = 8'd20;
   localparam logic [6:0] RESET_PACKET_BYTES     = 7'd64;
   localparam logic [7:0] RESET_FRAME_DESCRIPTOR = 8'd0;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] frame_columns;
      logic [7:0] frame_rows;
      logic [6:0] packet_bytes;
      logic [7:0] frame_descriptor;
   } cfg_type;

   // one classified sample: what the back end must emit for it
   typedef struct packed {
      logic       start;    // marker and descriptor first
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       two;      // byte1 is sent
      logic       commit;   // bare commit closes the frame
   } entry_type;

   typedef enum logic [4:0] {
      ST_MARK   = 5'b00001,
      ST_DESC   = 5'b00010,
      ST_B0     = 5'b00100,
      ST_B1     = 5'b01000,
      ST_COMMIT = 5'b10000
   } step_type;

endpackage

[design/pfsp_front.sv]
// ----------------------------------------------------------------------------
// pfsp_front
// accepts words, tracks the scan position and packs samples into bytes
// ----------------------------------------------------------------------------
module pfsp_front #(
   parameter int SAMPLES_PER_PIXEL = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  pfsp_pkg::cfg_type   cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [9:0]          req_sample,
   input  logic                q_full,
   output logic                q_push,
   output pfsp_pkg::entry_type q_entry
);

   localparam logic [3:0] SPP = 4'(SAMPLES_PER_PIXEL);

   logic [7:0] column_pos_ff, column_pos_in;
   logic [7:0] row_pos_ff, row_pos_in;
   logic [2:0] sample_in_pixel_ff, sample_in_pixel_in;
   logic [7:0] carry_bits_ff, carry_bits_in;
   logic [2:0] carry_count_ff, carry_count_in;
   logic       start_pending_ff, start_pending_in;

   logic       accept;
   logic [7:0] cb_eff;
   logic [2:0] cc_eff;
   logic [7:0] hi, lo, carry_new;
   logic [3:0] cc_sum;
   logic [7:0] last_col, last_row;
   logic       pixel_end;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept && !req_op;

   always_comb begin
      cb_eff    = start_pending_ff ? 8'd0 : carry_bits_ff;
      cc_eff    = start_pending_ff ? 3'd0 : carry_count_ff;
      hi        = req_sample[9:2];
      lo        = {req_sample[1:0], 6'd0};
      carry_new = (hi << (4'd8 - {1'b0, cc_eff})) | (lo >> cc_eff);
      cc_sum    = {1'b0, cc_eff} + 4'd2;
      last_col  = ((cfg.frame_columns == 8'd0) ? 8'd1 : cfg.frame_columns) - 8'd1;
      last_row  = ((cfg.frame_rows == 8'd0) ? 8'd1 : cfg.frame_rows) - 8'd1;
      pixel_end = ({1'b0, sample_in_pixel_ff} + 4'd1) >= SPP;

      q_entry.start  = start_pending_ff;
      q_entry.byte0  = cb_eff | (hi >> cc_eff);
      q_entry.byte1  = carry_new;
      q_entry.two    = cc_sum >= 4'd8;
      q_entry.commit = pixel_end && (column_pos_ff == last_col) && (row_pos_ff == last_row);

      column_pos_in      = column_pos_ff;
      row_pos_in         = row_pos_ff;
      sample_in_pixel_in = sample_in_pixel_ff;
      carry_bits_in      = carry_bits_ff;
      carry_count_in     = carry_count_ff;
      start_pending_in   = start_pending_ff;

      if (accept && req_op) begin
         column_pos_in      = 8'd0;
         row_pos_in         = 8'd0;
         sample_in_pixel_in = 3'd0;
         start_pending_in   = 1'b1;
      end else if (accept) begin
         start_pending_in = 1'b0;
         if (q_entry.two) begin
            carry_bits_in  = 8'd0;
            carry_count_in = 3'd0;
         end else begin
            carry_bits_in  = carry_new;
            carry_count_in = cc_sum[2:0];
         end
         if (pixel_end) begin
            sample_in_pixel_in = 3'd0;
            if (column_pos_ff >= last_col && row_pos_ff >= last_row) begin
               // exactly on the corner or beyond a shrunk frame
               column_pos_in    = 8'd0;
               row_pos_in       = 8'd0;
               start_pending_in = 1'b1;
            end else if (column_pos_ff >= last_col) begin
               column_pos_in = 8'd0;
               row_pos_in    = row_pos_ff + 8'd1;
            end else begin
               column_pos_in = column_pos_ff + 8'd1;
            end
         end else begin
            sample_in_pixel_in = sample_in_pixel_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_pos_ff      <= 8'd0;
         row_pos_ff         <= 8'd0;
         sample_in_pixel_ff <= 3'd0;
         carry_bits_ff      <= 8'd0;
         carry_count_ff     <= 3'd0;
         start_pending_ff   <= 1'b1;
      end else begin
         column_pos_ff      <= column_pos_in;
         row_pos_ff         <= row_pos_in;
         sample_in_pixel_ff <= sample_in_pixel_in;
         carry_bits_ff      <= carry_bits_in;
         carry_count_ff     <= carry_count_in;
         start_pending_ff   <= start_pending_in;
      end
   end

endmodule

[design/pfsp_queue.sv]
// ----------------------------------------------------------------------------
// pfsp_queue
// short first-in first-out queue of classified samples
// ----------------------------------------------------------------------------
`include "pixel_frame_sample_packer_unit_defines.svh"

module pfsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pfsp_pkg::entry_type push_entry,
   input  logic                pop,
   output pfsp_pkg::entry_type head,
   output logic                full,
   output logic                empty
);

   pfsp_pkg::entry_type slots_ff [pfsp_pkg::QUEUE_DEPTH];

   logic [pfsp_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [pfsp_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [pfsp_pkg::QCOUNT_W-1:0] count_ff, count_in;

   assign full  = count_ff == pfsp_pkg::QCOUNT_W'(pfsp_pkg::QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `PFSP_ASSERT_IMP(a_no_overflow, clock, reset, push, !full, "push into a full queue")
   `PFSP_ASSERT_IMP(a_no_underflow, clock, reset, pop, !empty, "pop from an empty queue")
   `PFSP_ASSERT_NXT(a_count_tracks, clock, reset, push && !pop && !full, !empty,
      "queue empty after a push")

endmodule

[design/pfsp_back.sv]
// ----------------------------------------------------------------------------
// pfsp_back
// expands queued samples into result words and keeps the packet count
// ----------------------------------------------------------------------------
`include "pixel_frame_sample_packer_unit_defines.svh"

module pfsp_back (
   input  logic                clock,
   input  logic                reset,
   input  pfsp_pkg::cfg_type   cfg,
   input  pfsp_pkg::entry_type head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_packet_end,
   output logic                rsp_last
);

   pfsp_pkg::step_type step_ff, step_in, cur_step, next_step;

   logic       mid_ff, mid_in;
   logic [6:0] fill_ff, fill_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bvalid_ff, bvalid_in;
   logic       pend_ff, pend_in;
   logic       last_ff, last_in;

   logic       load;
   logic       done;
   logic       is_commit;
   logic [7:0] cur_byte;
   logic [6:0] limit;
   logic [6:0] fill_next;

   assign load     = !valid_ff || rsp_ready;
   assign cur_step = mid_ff ? step_ff : (head.start ? pfsp_pkg::ST_MARK : pfsp_pkg::ST_B0);
   assign limit    = (cfg.packet_bytes == 7'd0) ? 7'd1 : cfg.packet_bytes;
   assign fill_next = fill_ff + 7'd1;

   always_comb begin
      next_step = pfsp_pkg::ST_B0;
      done      = 1'b0;
      cur_byte  = 8'd0;
      is_commit = 1'b0;
      unique case (cur_step)
         pfsp_pkg::ST_MARK: begin
            cur_byte  = pfsp_pkg::START_MARKER;
            next_step = pfsp_pkg::ST_DESC;
         end
         pfsp_pkg::ST_DESC: begin
            cur_byte  = cfg.frame_descriptor;
            next_step = pfsp_pkg::ST_B0;
         end
         pfsp_pkg::ST_B0: begin
            cur_byte = head.byte0;
            if (head.two) begin
               next_step = pfsp_pkg::ST_B1;
            end else if (head.commit) begin
               next_step = pfsp_pkg::ST_COMMIT;
            end else begin
               done = 1'b1;
            end
         end
         pfsp_pkg::ST_B1: begin
            cur_byte = head.byte1;
            if (head.commit) begin
               next_step = pfsp_pkg::ST_COMMIT;
            end else begin
               done = 1'b1;
            end
         end
         pfsp_pkg::ST_COMMIT: begin
            is_commit = 1'b1;
            done      = 1'b1;
         end
         default: begin
            done = 1'b1;
         end
      endcase
   end

   assign pop = load && !empty && done;

   always_comb begin
      step_in   = step_ff;
      mid_in    = mid_ff;
      fill_in   = fill_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      bvalid_in = bvalid_ff;
      pend_in   = pend_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in = !empty;
         if (!empty) begin
            byte_in   = cur_byte;
            bvalid_in = !is_commit;
            last_in   = done;
            mid_in    = !done;
            step_in   = next_step;
            // a bare commit always closes the packet, even an empty one
            if (is_commit || fill_next == limit) begin
               pend_in = 1'b1;
               fill_in = 7'd0;
            end else begin
               pend_in = 1'b0;
               fill_in = fill_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= pfsp_pkg::ST_B0;
         mid_ff   <= 1'b0;
         fill_ff  <= 7'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         mid_ff   <= mid_in;
         fill_ff  <= fill_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      bvalid_ff <= bvalid_in;
      pend_ff   <= pend_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_valid = bvalid_ff;
   assign rsp_packet_end = pend_ff;
   assign rsp_last       = last_ff;

   `PFSP_ASSERT_IMP(a_commit_closes, clock, reset, valid_ff && !bvalid_ff,
      pend_ff && last_ff && byte_ff == 8'd0, "bare commit word malformed")
   `PFSP_ASSERT_IMP(a_pop_ends_word, clock, reset, pop, !mid_in,
      "entry released mid sequence")

endmodule

[design/pixel_frame_sample_packer_unit.sv]
// ----------------------------------------------------------------------------
// pixel_frame_sample_packer_unit
// packs 10-bit pixel samples into a framed, packetised byte stream
// ----------------------------------------------------------------------------
// A restart word gives no result. A sample word is taken by the front end,
// which packs it and queues it in a four-deep queue; the back end then sends
// its results one per cycle while the receiver is ready: one or two data
// bytes, preceded by the start marker and descriptor on the first sample of a
// frame and followed by a bare commit on the last. The back end's one word per
// cycle, while the receiver is ready, sets the sustained rate. Configuration is
// to be written only while idle; the block itself does not enforce it.
module pixel_frame_sample_packer_unit #(
   parameter int SAMPLES_PER_PIXEL = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_op,
   input  logic [9:0] req_sample,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_packet_end,
   output logic       rsp_last
);

   pfsp_pkg::cfg_type   cfg_ff, cfg_in;
   pfsp_pkg::entry_type push_entry, head;

   logic push, pop, full, empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            pfsp_pkg::CSR_FRAME_COLUMNS:    cfg_in.frame_columns    = csr_wdata;
            pfsp_pkg::CSR_FRAME_ROWS:       cfg_in.frame_rows       = csr_wdata;
            pfsp_pkg::CSR_PACKET_BYTES:     cfg_in.packet_bytes     = csr_wdata[6:0];
            pfsp_pkg::CSR_FRAME_DESCRIPTOR: cfg_in.frame_descriptor = csr_wdata;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_columns    <= pfsp_pkg::RESET_FRAME_COLUMNS;
         cfg_ff.frame_rows       <= pfsp_pkg::RESET_FRAME_ROWS;
         cfg_ff.packet_bytes     <= pfsp_pkg::RESET_PACKET_BYTES;
         cfg_ff.frame_descriptor <= pfsp_pkg::RESET_FRAME_DESCRIPTOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pfsp_front #(
      .SAMPLES_PER_PIXEL(SAMPLES_PER_PIXEL)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_sample (req_sample),
      .q_full     (full),
      .q_push     (push),
      .q_entry    (push_entry)
   );

   pfsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (full),
      .empty      (empty)
   );

   pfsp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head           (head),
      .empty          (empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_packet_end (rsp_packet_end),
      .rsp_last       (rsp_last)
   );

endmodule

[sim/pixel_frame_sample_packer_unit_scoreboard.sv]
// ----------------------------------------------------------------------------
// pixel frame sample packer scoreboard
// predicts the framed byte stream for each accepted input word and checks
// every result word against the oldest prediction, field by field
// ----------------------------------------------------------------------------
package pfsp_tb_pkg;

   localparam int PIXEL_SAMPLES = 4;

   typedef enum logic {
      OP_SAMPLE  = 1'b0,
      OP_RESTART = 1'b1
   } word_op_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       packet_end;
      logic       last;
   } stream_word_type;

   class stream_scoreboard;
      // register copies
      logic [7:0] columns;
      logic [7:0] rows;
      logic [6:0] pkt_len;
      logic [7:0] descriptor;
      // scan and packing state
      logic [7:0] col_pos;
      logic [7:0] row_pos;
      logic [2:0] sample_idx;
      logic [7:0] carry;
      logic [2:0] carry_held;
      logic [6:0] fill;
      logic       start_armed;

      stream_word_type expected_bytes[$];
      int              mismatch_count;
      int              checked_count;

      function new();
         columns        = pfsp_pkg::RESET_FRAME_COLUMNS;
         rows           = pfsp_pkg::RESET_FRAME_ROWS;
         pkt_len        = pfsp_pkg::RESET_PACKET_BYTES;
         descriptor     = pfsp_pkg::RESET_FRAME_DESCRIPTOR;
         carry          = 8'd0;
         carry_held     = 3'd0;
         fill           = 7'd0;
         mismatch_count = 0;
         checked_count  = 0;
         rewind();
      endfunction

      function void rewind();
         col_pos     = 8'd0;
         row_pos     = 8'd0;
         sample_idx  = 3'd0;
         start_armed = 1'b1;
      endfunction

      function void set_register(logic [1:0] idx, logic [7:0] value);
         case (idx)
            pfsp_pkg::CSR_FRAME_COLUMNS:    columns    = value;
            pfsp_pkg::CSR_FRAME_ROWS:       rows       = value;
            pfsp_pkg::CSR_PACKET_BYTES:     pkt_len    = value[6:0];
            pfsp_pkg::CSR_FRAME_DESCRIPTOR: descriptor = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      // one stream word, with the packet fill advanced
      function stream_word_type frame_byte(logic [7:0] data, logic data_valid,
                                           logic commit);
         stream_word_type w;
         logic [6:0]      limit;
         logic [6:0]      next_fill;
         limit        = (pkt_len == 7'd0) ? 7'd1 : pkt_len;
         next_fill    = fill + 7'd1;
         w.out_byte   = data;
         w.byte_valid = data_valid;
         w.last       = 1'b0;
         if (commit || next_fill == limit) begin
            w.packet_end = 1'b1;
            fill         = 7'd0;
         end else begin
            w.packet_end = 1'b0;
            fill         = next_fill;
         end
         return w;
      endfunction

      function void note_word(logic op, logic [9:0] sample);
         stream_word_type burst[$];
         stream_word_type w;
         logic [7:0]      hi;
         logic [7:0]      lo;
         logic [3:0]      held;
         logic [7:0]      last_col;
         logic [7:0]      last_row;
         if (op == OP_RESTART) begin
            rewind();
            return;
         end
         if (start_armed) begin
            start_armed = 1'b0;
            burst.push_back(frame_byte(pfsp_pkg::START_MARKER, 1'b1, 1'b0));
            burst.push_back(frame_byte(descriptor, 1'b1, 1'b0));
            carry      = 8'd0;
            carry_held = 3'd0;
         end
         // sample left-justified: eight high bits, then the two low ones on top
         hi   = sample[9:2];
         lo   = {sample[1:0], 6'd0};
         held = {1'b0, carry_held};
         burst.push_back(frame_byte(carry | (hi >> held), 1'b1, 1'b0));
         carry = (hi << (4'd8 - held)) | (lo >> held);
         held  = held + 4'd2;
         if (held >= 4'd8) begin
            burst.push_back(frame_byte(carry, 1'b1, 1'b0));
            carry = 8'd0;
            held  = 4'd0;
         end
         carry_held = held[2:0];
         if (int'(sample_idx) + 1 >= PIXEL_SAMPLES) begin
            last_col   = ((columns == 8'd0) ? 8'd1 : columns) - 8'd1;
            last_row   = ((rows == 8'd0) ? 8'd1 : rows) - 8'd1;
            sample_idx = 3'd0;
            if (col_pos == last_col && row_pos == last_row) begin
               burst.push_back(frame_byte(8'd0, 1'b0, 1'b1));
               rewind();
            end else if (col_pos >= last_col && row_pos >= last_row) begin
               // scan left outside a shrunken frame
               rewind();
            end else if (col_pos >= last_col) begin
               col_pos = 8'd0;
               row_pos = row_pos + 8'd1;
            end else begin
               col_pos = col_pos + 8'd1;
            end
         end else begin
            sample_idx = sample_idx + 3'd1;
         end
         w      = burst.pop_back();
         w.last = 1'b1;
         burst.push_back(w);
         foreach (burst[i])
            expected_bytes.push_back(burst[i]);
      endfunction

      task report(string msg);
         mismatch_count++;
         $display("mismatch at word %0d: %s", checked_count, msg);
      endtask

      task check_word(stream_word_type got);
         stream_word_type want;
         if (expected_bytes.size() == 0) begin
            report($sformatf("word %02h/%0b/%0b/%0b with nothing expected",
                   got.out_byte, got.byte_valid, got.packet_end, got.last));
         end else begin
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
               report($sformatf("out_byte got %02h want %02h", got.out_byte, want.out_byte));
            if (got.byte_valid !== want.byte_valid)
               report($sformatf("byte_valid got %0b want %0b", got.byte_valid,
                      want.byte_valid));
            if (got.packet_end !== want.packet_end)
               report($sformatf("packet_end got %0b want %0b", got.packet_end,
                      want.packet_end));
            if (got.last !== want.last)
               report($sformatf("last got %0b want %0b", got.last, want.last));
         end
         checked_count++;
      endtask
   endclass

endpackage

[sim/pixel_frame_sample_packer_unit_tb.sv]
// ----------------------------------------------------------------------------
// pixel_frame_sample_packer_unit_tb
// drives sample and restart words through the packer under several frame and
// packet settings, with random gaps and back-pressure, and checks the byte
// stream against the scoreboard's prediction
// ----------------------------------------------------------------------------
module pixel_frame_sample_packer_unit_tb;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_WORDS   = 13;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;
   logic       req_valid;
   logic       req_ready;
   logic       req_op;
   logic [9:0] req_sample;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_packet_end;
   logic       rsp_last;

   pfsp_tb_pkg::stream_scoreboard sb;
   pfsp_tb_pkg::stream_word_type  seen;
   bit                            steady_tail = 1'b0;

   pixel_frame_sample_packer_unit #(
      .SAMPLES_PER_PIXEL(pfsp_tb_pkg::PIXEL_SAMPLES)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_packet_end  (rsp_packet_end),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side back-pressure in bursts
   initial begin : ready_driver
      int run;
      bit stall;
      run       = 0;
      stall     = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (run == 0) begin
            stall = ($urandom_range(0, 2) == 0);
            run   = stall ? $urandom_range(1, 10) : $urandom_range(1, 20);
         end
         rsp_ready = steady_tail || !stall;
         run--;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen.out_byte   = rsp_out_byte;
            seen.byte_valid = rsp_byte_valid;
            seen.packet_end = rsp_packet_end;
            seen.last       = rsp_last;
            sb.check_word(seen);
         end
         if (req_valid && req_ready)
            sb.note_word(req_op, req_sample);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // called on a falling edge, returns on the falling edge after acceptance
   task automatic send_word(pfsp_tb_pkg::word_op_type op, logic [9:0] sample);
      req_valid  = 1'b1;
      req_op     = op;
      req_sample = sample;
      do
         @(posedge clock);
      while (!req_ready);
      @(negedge clock);
   endtask

   task automatic sender_gap();
      if (!steady_tail && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   task automatic send_sample(logic [9:0] sample);
      sender_gap();
      send_word(pfsp_tb_pkg::OP_SAMPLE, sample);
   endtask

   // hold the sender until the stream has fully drained
   task automatic drain_stream();
      req_valid = 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [7:0] value);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_wdata        = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.set_register(idx, value);
   endtask

   task automatic set_frame(logic [7:0] cols, logic [7:0] rows, logic [7:0] pkt,
                            logic [7:0] desc);
      write_register(pfsp_pkg::CSR_FRAME_COLUMNS, cols);
      write_register(pfsp_pkg::CSR_FRAME_ROWS, rows);
      write_register(pfsp_pkg::CSR_PACKET_BYTES, pkt);
      write_register(pfsp_pkg::CSR_FRAME_DESCRIPTOR, desc);
   endtask

   task automatic random_frame();
      logic [7:0] cols;
      logic [7:0] rows;
      logic [7:0] pkt;
      case ($urandom_range(0, 7))
         0:       cols = 8'd0;
         1:       cols = 8'd255;
         default: cols = 8'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 7))
         0:       rows = 8'd0;
         1:       rows = 8'd255;
         default: rows = 8'($urandom_range(1, 3));
      endcase
      case ($urandom_range(0, 9))
         0:       pkt = 8'd0;
         1:       pkt = 8'd64;
         2:       pkt = 8'd127;
         3:       pkt = 8'hFF;
         default: pkt = 8'($urandom_range(1, 8));
      endcase
      set_frame(cols, rows, pkt, 8'($urandom_range(0, 255)));
   endtask

   task automatic random_words(int count, bit pause_midway);
      for (int i = 0; i < count; i++) begin
         if (pause_midway && i == count / 2)
            drain_stream();
         sender_gap();
         if ($urandom_range(0, 19) == 0)
            send_word(pfsp_tb_pkg::OP_RESTART, 10'($urandom_range(0, 1023)));
         else
            send_word(pfsp_tb_pkg::OP_SAMPLE, 10'($urandom_range(0, 1023)));
      end
   endtask

   initial begin
      sb               = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = pfsp_tb_pkg::OP_SAMPLE;
      req_sample       = 10'd0;
      csr_write_enable = 1'b0;
      csr_index        = pfsp_pkg::CSR_FRAME_COLUMNS;
      csr_wdata        = 8'd0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // reset settings: field extremes and a restart mid-frame after the first pixel
      send_sample(10'h3FF);
      send_sample(10'h000);
      send_sample(10'h2AA);
      send_sample(10'h155);
      sender_gap();
      send_word(pfsp_tb_pkg::OP_RESTART, 10'h3FF);
      send_sample(10'h001);

      // one-pixel frames with one-byte packets: commit right after a full packet
      drain_stream();
      set_frame(8'd1, 8'd1, 8'd1, 8'hFF);
      send_sample(10'h3FF);
      send_sample(10'h000);
      send_sample(10'h3FF);
      send_sample(10'h000);

      // zero sizes act as one, oversize packet value cut to its low seven bits
      drain_stream();
      set_frame(8'd0, 8'd0, 8'hFF, 8'h5A);
      send_sample(10'h200);
      send_sample(10'h1FF);
      send_sample(10'h100);
      send_sample(10'h0FF);

      // stop mid-frame, then shrink the frame under the scan position
      drain_stream();
      set_frame(8'd2, 8'd2, 8'd0, 8'h00);
      for (int i = 0; i < 8; i++)
         send_sample(10'($urandom_range(0, 1023)));
      drain_stream();
      set_frame(8'd1, 8'd1, 8'd3, 8'hA5);
      for (int i = 0; i < 4; i++)
         send_sample(10'($urandom_range(0, 1023)));

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_stream();
         random_frame();
         if (p == RANDOM_PHASES - 1)
            steady_tail = 1'b1;
         random_words(PHASE_WORDS, p == 2);
      end

      drain_stream();
      if (sb.mismatch_count == 0 && sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
